// File: rtl/kcm_pkg.sv
// ----------------------------------------------------------------------------
// kcm_pkg: shared types and codes of the keyed count merge table
// Result codes, item modes and the request token that walks the cell row.
// ----------------------------------------------------------------------------
package kcm_pkg;

  localparam int COUNT_W   = 32;
  localparam int IDX_W     = 7;
  localparam int DIST_W    = 8;
  localparam int KEY_W_MAX = 240;

  localparam logic MODE_MERGE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_MERGED      = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_DROPPED     = 3'd2,
    ST_EMPTY_KEY   = 3'd3,
    ST_READ_OK     = 3'd4,
    ST_READ_UNUSED = 3'd5
  } status_t;

  // Request token handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 done;
    status_t              status;
    logic [IDX_W-1:0]     index;
    logic [COUNT_W-1:0]   count;
  } kcm_tok_t;

endpackage

// File: rtl/kcm_cell.sv
// ----------------------------------------------------------------------------
// kcm_cell: one table entry of the keyed count merge table
// Holds one key and its count; checks the passing request against them and
// hands the request on to the next cell through its token register.
// ----------------------------------------------------------------------------
module kcm_cell
  import kcm_pkg::*;
#(
  parameter int IDX  = 0,
  parameter int KW   = 240,
  parameter int CNTW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNTW-1:0]     used_i,
  input  logic                mode_i,
  input  logic [KW-1:0]       key_i,
  input  logic [COUNT_W-1:0]  add_i,
  input  logic [IDX_W-1:0]    read_index_i,
  input  kcm_tok_t            tok_i,
  input  logic [KW-1:0]       tok_key_i,
  output kcm_tok_t            tok_o,
  output logic [KW-1:0]       tok_key_o
);

  localparam logic [CNTW-1:0]  IDX_C   = CNTW'(IDX);
  localparam logic [IDX_W-1:0] IDX_LOW = IDX_W'(IDX);
  localparam logic             READABLE = (IDX < (1 << IDX_W));

  logic [KW-1:0]      key_r, key_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  kcm_tok_t           tok_r, tok_nxt;
  logic [KW-1:0]      tok_key_r, tok_key_nxt;
  logic               in_use;
  logic               rd_hit;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sum_sat;

  assign in_use  = (IDX_C < used_i);
  assign rd_hit  = READABLE && (read_index_i == IDX_LOW) && in_use;
  assign sum     = {1'b0, count_r} + {1'b0, add_i};
  assign sum_sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];

  always_comb begin
    tok_nxt     = tok_i;
    tok_key_nxt = tok_key_i;
    key_nxt     = key_r;
    count_nxt   = count_r;
    if (tok_i.valid && !tok_i.done) begin
      if (mode_i == MODE_READ) begin
        if (rd_hit) begin
          tok_nxt.done   = 1'b1;
          tok_nxt.status = ST_READ_OK;
          tok_nxt.count  = count_r;
          tok_key_nxt    = key_r;
        end
      end else if (in_use && (key_r == key_i)) begin
        count_nxt      = sum_sat;
        tok_nxt.done   = 1'b1;
        tok_nxt.status = ST_MERGED;
        tok_nxt.index  = IDX_LOW;
        tok_nxt.count  = sum_sat;
      end else if (!in_use) begin
        // first free entry: claim it
        key_nxt        = key_i;
        count_nxt      = add_i;
        tok_nxt.done   = 1'b1;
        tok_nxt.status = ST_INSERTED;
        tok_nxt.index  = IDX_LOW;
        tok_nxt.count  = add_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    count_r   <= count_nxt;
    tok_key_r <= tok_key_nxt;
  end

  assign tok_o     = tok_r;
  assign tok_key_o = tok_key_r;

endmodule

// File: rtl/keyed_count_merge_table.sv
// ----------------------------------------------------------------------------
// keyed_count_merge_table: associative key/count table on a row of cells
// Merges keyed counts into up to ENTRIES distinct entries, or reads one back.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata                                   | tuser
//  in_     | in  | keys, add_count, read_index             | mode
//  out_    | out | entry_index, entry_count, distinct, keys| status
//
//  One request at a time walks the row of ENTRIES cells, one cell a cycle;
//  its result then goes through a holding stage and the output register. A
//  new request is taken once the row is free and the holding stage empty.
//  A finished result waits in a holding stage, so one more request is taken
//  while the output is stalled. Reset empties the table at once (no sweep).
// ----------------------------------------------------------------------------
module keyed_count_merge_table
  import kcm_pkg::*;
#(
  parameter int ENTRIES   = 128,
  parameter int KEY_BYTES = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] key_bytes_0_7, [127:64] key_bytes_8_15, [191:128] key_bytes_16_23,
  // [239:192] key_bytes_24_29, [271:240] add_count, [278:272] read_index
  input  logic [279:0] in_tdata,
  // [0] mode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [6:0] entry_index, [38:7] entry_count, [46:39] distinct_entries,
  // [110:47] out_key_0_7, [174:111] out_key_8_15, [238:175] out_key_16_23,
  // [286:239] out_key_24_29
  output logic [287:0] out_tdata,
  // [2:0] status
  output logic [2:0]   out_tuser
);

  localparam int KW   = KEY_BYTES * 8;
  localparam int CNTW = $clog2(ENTRIES + 1);

  logic [KEY_W_MAX-1:0] raw_key;
  logic [KW-1:0]        norm_key;
  logic                 alive;
  logic                 in_acc;

  logic                 busy_r;
  logic                 mode_r;
  logic [KW-1:0]        key_r;
  logic [COUNT_W-1:0]   add_r;
  logic [IDX_W-1:0]     ridx_r;
  kcm_tok_t             start_r, start_nxt;
  logic [CNTW-1:0]      used_r, used_nxt;

  kcm_tok_t             tok_chain [ENTRIES+1];
  logic [KW-1:0]        key_chain [ENTRIES+1];
  kcm_tok_t             exit_tok;

  logic                 res_valid_r;
  kcm_tok_t             res_tok_r;
  logic [KW-1:0]        res_key_r;
  logic [DIST_W-1:0]    res_dist_r;
  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [286:0]         out_data_r;
  logic                 out_load;

  assign raw_key = in_tdata[239:0];
  assign in_acc  = in_tvalid && in_tready;

  // truncate the key at its first zero byte
  always_comb begin
    alive    = 1'b1;
    norm_key = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      alive = alive && (raw_key[b*8 +: 8] != 8'd0);
      if (alive) begin
        norm_key[b*8 +: 8] = raw_key[b*8 +: 8];
      end
    end
  end

  always_comb begin
    start_nxt        = '0;
    start_nxt.valid  = in_acc;
    if (in_tuser[0] == MODE_READ) begin
      start_nxt.status = ST_READ_UNUSED;
      start_nxt.index  = in_tdata[278:272];
    end else if (norm_key[7:0] == 8'd0) begin
      start_nxt.done   = 1'b1;
      start_nxt.status = ST_EMPTY_KEY;
    end else begin
      start_nxt.status = ST_DROPPED;
    end
  end

  assign in_tready = !busy_r && !res_valid_r;
  assign exit_tok  = tok_chain[ENTRIES];
  assign used_nxt  = (exit_tok.valid && exit_tok.status == ST_INSERTED) ?
                     used_r + CNTW'(1) : used_r;
  assign out_load  = res_valid_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= '0;
      used_r      <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= start_nxt;
      used_r  <= used_nxt;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (exit_tok.valid) begin
        busy_r <= 1'b0;
      end
      if (exit_tok.valid) begin
        res_valid_r <= 1'b1;
      end else if (out_load) begin
        res_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tuser[0];
      key_r  <= norm_key;
      add_r  <= in_tdata[271:240];
      ridx_r <= in_tdata[278:272];
    end
    if (exit_tok.valid) begin
      res_tok_r  <= exit_tok;
      res_key_r  <= key_chain[ENTRIES];
      res_dist_r <= DIST_W'(used_nxt);
    end
    if (out_load) begin
      out_status_r <= res_tok_r.status;
      out_data_r   <= {KEY_W_MAX'(res_key_r), res_dist_r, res_tok_r.count,
                       res_tok_r.index};
    end
  end

  assign tok_chain[0] = start_r;
  assign key_chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kcm_cell #(
      .IDX  (i),
      .KW   (KW),
      .CNTW (CNTW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .used_i       (used_r),
      .mode_i       (mode_r),
      .key_i        (key_r),
      .add_i        (add_r),
      .read_index_i (ridx_r),
      .tok_i        (tok_chain[i]),
      .tok_key_i    (key_chain[i]),
      .tok_o        (tok_chain[i+1]),
      .tok_key_o    (key_chain[i+1])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNTW'(ENTRIES))
    else $error("entry count beyond table size");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (exit_tok.valid && exit_tok.status == ST_INSERTED) |-> (used_r < CNTW'(ENTRIES)))
    else $error("insert into a full table");

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    exit_tok.valid |-> busy_r)
    else $error("request left the cell row while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (busy_r && start_r.valid))
    else $error("accepted request not launched");
`endif

endmodule

// File: tb/keyed_count_merge_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_count_merge_table_test: self-checking bench for the keyed count table
// Streams merge and read requests through the table, with random idling on
// both channels, and checks each result against a behavioural table copy.
// ----------------------------------------------------------------------------
module keyed_count_merge_table_test;
  import kcm_pkg::*;

  localparam int ENTRIES   = 128;
  localparam int KEY_BYTES = 30;
  localparam int KEY_W     = 240;
  localparam int N_RANDOM  = 1800;
  localparam int SETTLE    = 2 * (ENTRIES + 3) + 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic               mode;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] add;
    logic [IDX_W-1:0]   read_idx;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   index;
    logic [COUNT_W-1:0] count;
    logic [DIST_W-1:0]  distinct;
    logic [KEY_W-1:0]   key;
  } result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [279:0] in_tdata   = '0;
  logic [0:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic [2:0]   out_tuser;

  // Behavioural copy of the table
  logic [KEY_W-1:0]   tbl_key   [ENTRIES];
  logic [COUNT_W-1:0] tbl_count [ENTRIES];
  int                 tbl_used = 0;

  request_t request_queue [$];
  result_t  pending_results [$];
  logic     req_taken    = 1'b0;
  int       accepted_cnt = 0;
  int       mismatches   = 0;
  logic     calm;
  request_t drive_req;
  request_t seen_req;
  result_t  got_res;
  result_t  want_res;

  keyed_count_merge_table #(
    .ENTRIES   (ENTRIES),
    .KEY_BYTES (KEY_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // No idling on either side for a stretch in the middle of the run
  assign calm = (accepted_cnt >= 700) && (accepted_cnt < 1000);

  function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    bit               ended;
    k     = '0;
    ended = 1'b0;
    for (int b = 0; b < 30; b++) begin
      if (b >= KEY_BYTES || raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) k[8*b +: 8] = raw[8*b +: 8];
    end
    return k;
  endfunction

  function automatic result_t tally_request(request_t r);
    result_t            res;
    logic [KEY_W-1:0]   k;
    logic [COUNT_W:0]   sum;
    int                 slot;
    res  = '0;
    slot = -1;
    if (r.mode == MODE_READ) begin
      res.index = r.read_idx;
      if (int'(r.read_idx) < tbl_used) begin
        res.status = ST_READ_OK;
        res.count  = tbl_count[r.read_idx];
        res.key    = tbl_key[r.read_idx];
      end else begin
        res.status = ST_READ_UNUSED;
      end
    end else begin
      k = trim_key(r.key);
      if (k[7:0] == 8'h00) begin
        res.status = ST_EMPTY_KEY;
      end else begin
        for (int e = 0; e < tbl_used; e++)
          if (slot < 0 && tbl_key[e] == k) slot = e;
        if (slot >= 0) begin
          sum             = {1'b0, tbl_count[slot]} + r.add;
          tbl_count[slot] = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
          res.status      = ST_MERGED;
          res.index       = slot[IDX_W-1:0];
          res.count       = tbl_count[slot];
        end else if (tbl_used < ENTRIES) begin
          tbl_key[tbl_used]   = k;
          tbl_count[tbl_used] = r.add;
          res.status          = ST_INSERTED;
          res.index           = tbl_used[IDX_W-1:0];
          res.count           = r.add;
          tbl_used++;
        end else begin
          res.status = ST_DROPPED;
        end
      end
    end
    res.distinct = tbl_used[DIST_W-1:0];
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] random_key_bits();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    return v[KEY_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(1000);
    if (pick < 90) return $urandom;
    return COUNT_MAX - $urandom_range(255);
  endfunction

  task automatic queue_request(logic mode, logic [KEY_W-1:0] key,
                               logic [COUNT_W-1:0] add, logic [IDX_W-1:0] idx);
    request_t r;
    r.mode     = mode;
    r.key      = key;
    r.add      = add;
    r.read_idx = idx;
    request_queue.push_back(r);
  endtask

  // Driver: present the next request at the falling edge, hold until taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || req_taken)) begin
      if (request_queue.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
        drive_req = request_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drive_req.mode;
        in_tdata  <= {1'b0, drive_req.read_idx, drive_req.add, drive_req.key};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && (calm || $urandom_range(99) >= 34);
  end

  // Predict on each accepted request, in order of acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        seen_req.mode     = in_tuser[0];
        seen_req.key      = in_tdata[239:0];
        seen_req.add      = in_tdata[271:240];
        seen_req.read_idx = in_tdata[278:272];
        pending_results.push_back(tally_request(seen_req));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.status   = status_t'(out_tuser);
      got_res.index    = out_tdata[6:0];
      got_res.count    = out_tdata[38:7];
      got_res.distinct = out_tdata[46:39];
      got_res.key      = out_tdata[286:47];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result, status %0d index %0d", $realtime,
                   got_res.status, got_res.index);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected status %0d index %0d count %h distinct %0d key %h",
                     want_res.status, want_res.index, want_res.count,
                     want_res.distinct, want_res.key);
            $display("  actual   status %0d index %0d count %h distinct %0d key %h",
                     got_res.status, got_res.index, got_res.count,
                     got_res.distinct, got_res.key);
          end
        end
      end
    end
  end

  initial begin
    request_t         req;
    int               roll;
    int               len;
    int               limit;
    logic [KEY_W-1:0] key_pool [$];

    // Directed requests on an empty table
    queue_request(MODE_READ,  '0, '0, 7'd0);
    queue_request(MODE_READ,  '0, '0, 7'd127);
    queue_request(MODE_MERGE, {{232{1'b1}}, 8'h00}, COUNT_MAX, '1);
    queue_request(MODE_MERGE, '1, COUNT_MAX, '1);
    queue_request(MODE_MERGE, '1, 32'd1, 7'd0);
    queue_request(MODE_MERGE, {{216{1'b1}}, 24'h006261}, 32'd5, '1);
    queue_request(MODE_MERGE, {224'h0, 16'h6261}, 32'd0, 7'd0);
    queue_request(MODE_MERGE, {216'h0, 24'h636261}, 32'h7FFF_FFFF, 7'd0);
    queue_request(MODE_MERGE, {216'h0, 24'h636261}, 32'h8000_0000, 7'd0);
    queue_request(MODE_MERGE, {216'h0, 24'h636261}, 32'd1, 7'd0);
    queue_request(MODE_MERGE, {8'h01, {232{1'b1}}}, 32'd0, 7'd0);
    queue_request(MODE_MERGE, {232'h0, 8'h01}, 32'd0, 7'd0);
    queue_request(MODE_READ,  '1, COUNT_MAX, 7'd0);
    for (int i = 1; i <= 5; i++) queue_request(MODE_READ, '0, '0, i[IDX_W-1:0]);
    queue_request(MODE_MERGE, '0, '0, 7'd0);

    for (int n = 0; n < N_RANDOM; n++) begin
      roll         = $urandom_range(99);
      limit        = (key_pool.size() < ENTRIES + 8) ? key_pool.size() : ENTRIES + 8;
      req.mode     = MODE_MERGE;
      req.key      = random_key_bits();
      req.add      = random_count();
      req.read_idx = IDX_W'($urandom_range(127));
      if (roll < 28) begin
        req.mode = MODE_READ;
        if (limit > 0 && $urandom_range(2) != 0)
          req.read_idx = IDX_W'($urandom_range(limit - 1));
      end else if (roll < 33) begin
        req.key[7:0] = 8'h00;
      end else if (roll < 55 || limit == 0) begin
        // Fresh key: random length, optional junk past the terminator
        len = ($urandom_range(3) == 0) ? KEY_BYTES : $urandom_range(1, KEY_BYTES);
        for (int b = 0; b < len; b++) req.key[8*b +: 8] = 8'($urandom_range(1, 255));
        if (len < 30) req.key[8*len +: 8] = 8'h00;
        if ($urandom_range(1) == 0) req.key = trim_key(req.key);
        key_pool.push_back(req.key);
      end else begin
        req.key = key_pool[$urandom_range(limit - 1)];
        if ($urandom_range(1) == 0) req.key = trim_key(req.key);
      end
      request_queue.push_back(req);
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (request_queue.size() != 0 || in_tvalid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
rtl/kcm_pkg.sv
rtl/kcm_cell.sv
rtl/keyed_count_merge_table.sv
tb/keyed_count_merge_table_test.sv
